// ----- design/nfba_pkg.sv -----
`timescale 1ns / 1ps

package nfba_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int SCAN_W     = $clog2(WORD_COUNT + 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        t_word              wr_data;
    } t_mem_req;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] index;
    } t_zero_hit;

    // Lowest clear bit of a word: isolate it, then encode the one-hot result.
    function automatic t_zero_hit lowest_zero(input t_word w);
        t_word     inv;
        t_word     onehot;
        t_zero_hit hit;
        inv       = ~w;
        onehot    = inv & (~inv + t_word'(1));
        hit.found = |inv;
        hit.index = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (onehot[i]) begin
                hit.index = hit.index | OFF_W'(i);
            end
        end
        return hit;
    endfunction

endpackage

// ----- design/nfba_bitmap_ram.sv -----
`timescale 1ns / 1ps

module nfba_bitmap_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfba_pkg::t_mem_req i_req,
    output nfba_pkg::t_word   o_rdata
);
    import nfba_pkg::*;

    t_word                 mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_word_valid;
    t_word                 r_rdata;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[i_req.rd_addr];
        end
    end

    // A word never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_word_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_word_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

// ----- design/next_fit_bitmap_slot_allocator.sv -----
`timescale 1ns / 1ps

// Next-fit slot allocator over a pool of SLOT_COUNT slots kept as an in-use bitmap in a small
// synchronous RAM of WORD_BITS-bit words. An item is taken when start is high and busy is low;
// its result appears on the o_ ports for exactly one cycle with o_valid high, and the receiver
// must take it then, since the block cannot hold it. An allocate on a full pool answers in the
// cycle after it is taken. An allocate otherwise reads one bitmap word per cycle from the head
// word onward and answers once a free bit turns up, after at most WORD_COUNT + 1 words. A free
// reads the word that holds the slot, then writes it back with the bit cleared if it was set,
// and answers. busy stays high until the result is registered, so the next item follows in the
// cycle the result shows. The bitmap is free after reset with no clearing.
module next_fit_bitmap_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [7:0]                    i_free_slot,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_granted_slot,
    output logic [nfba_pkg::CNT_W-1:0]    o_used_count
);
    import nfba_pkg::*;

    t_state              r_state, n_state;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_granted, n_granted;
    logic [CNT_W-1:0]    r_used_total, n_used_total;
    logic [SLOT_W-1:0]   r_next_try, n_next_try;
    logic [WADDR_W-1:0]  r_scan_addr, n_scan_addr;
    logic [SCAN_W-1:0]   r_scan_cnt, n_scan_cnt;
    logic [SLOT_W-1:0]   r_free_slot, n_free_slot;

    t_mem_req            mem_req;
    t_word               mem_rdata;
    t_word               scan_word;
    t_word               below_head;
    t_zero_hit           hit;
    logic                accept;
    logic                pool_full;
    logic                slot_in_pool;
    logic                free_bit;

    nfba_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign pool_full    = (r_used_total >= CNT_W'(SLOT_COUNT));
    assign slot_in_pool = ({1'b0, i_free_slot} < 9'(SLOT_COUNT));

    // On the first word of a scan the slots below the head count as taken.
    assign below_head = ~({WORD_BITS{1'b1}} << r_next_try[OFF_W-1:0]);
    assign scan_word  = mem_rdata | ((r_scan_cnt == '0) ? below_head : '0);
    assign hit        = lowest_zero(scan_word);
    assign free_bit   = mem_rdata[r_free_slot[OFF_W-1:0]];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_ALLOC) begin
                        n_state = pool_full ? S_IDLE : S_SCAN;
                    end else begin
                        n_state = slot_in_pool ? S_FREE : S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (hit.found || (r_scan_cnt == SCAN_W'(WORD_COUNT))) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid      = 1'b0;
        n_status     = r_status;
        n_granted    = r_granted;
        n_used_total = r_used_total;
        n_next_try   = r_next_try;
        n_scan_addr  = r_scan_addr;
        n_scan_cnt   = r_scan_cnt;
        n_free_slot  = r_free_slot;
        mem_req      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_ALLOC) begin
                        if (pool_full) begin
                            n_valid   = 1'b1;
                            n_status  = ST_FULL;
                            n_granted = '0;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = WADDR_W'(r_next_try >> OFF_W);
                            n_scan_addr     = WADDR_W'(r_next_try >> OFF_W);
                            n_scan_cnt      = '0;
                        end
                    end else begin
                        n_free_slot = SLOT_W'(i_free_slot);
                        if (slot_in_pool) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = WADDR_W'(i_free_slot >> OFF_W);
                        end else begin
                            n_valid   = 1'b1;
                            n_status  = ST_NOT_USED;
                            n_granted = '0;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (hit.found) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_scan_addr;
                    mem_req.wr_data = mem_rdata | (t_word'(1) << hit.index);
                    n_valid         = 1'b1;
                    n_status        = ST_OK;
                    n_granted       = SLOT_W'({r_scan_addr, hit.index});
                    n_next_try      = SLOT_W'({r_scan_addr, hit.index}) + SLOT_W'(1);
                    n_used_total    = r_used_total + CNT_W'(1);
                end else if (r_scan_cnt == SCAN_W'(WORD_COUNT)) begin
                    n_valid   = 1'b1;
                    n_status  = ST_FULL;
                    n_granted = '0;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_scan_addr + WADDR_W'(1);
                    n_scan_addr     = r_scan_addr + WADDR_W'(1);
                    n_scan_cnt      = r_scan_cnt + SCAN_W'(1);
                end
            end
            S_FREE: begin
                n_valid   = 1'b1;
                n_granted = '0;
                if (free_bit) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = WADDR_W'(r_free_slot >> OFF_W);
                    mem_req.wr_data = mem_rdata & ~(t_word'(1) << r_free_slot[OFF_W-1:0]);
                    n_status        = ST_OK;
                    if (r_used_total != '0) begin
                        n_used_total = r_used_total - CNT_W'(1);
                    end
                end else begin
                    n_status = ST_NOT_USED;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_used_total <= '0;
            r_next_try   <= '0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_used_total <= n_used_total;
            r_next_try   <= n_next_try;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_granted   <= n_granted;
        r_scan_addr <= n_scan_addr;
        r_scan_cnt  <= n_scan_cnt;
        r_free_slot <= n_free_slot;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_granted_slot = 8'(r_granted);
    assign o_used_count   = r_used_total;

endmodule

// ----- bench/tb_next_fit_bitmap_slot_allocator.sv -----
`timescale 1ns / 1ps

module tb_next_fit_bitmap_slot_allocator;
    import nfba_pkg::*;

    localparam int   CYCLE_LIMIT = 200000;

    typedef struct {
        t_status          status;
        logic [7:0]       slot;
        logic [CNT_W-1:0] count;
    } t_pool_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_command = CMD_ALLOC;
    logic [7:0]         i_free_slot = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [7:0]         o_granted_slot;
    logic [CNT_W-1:0]   o_used_count;

    // Shadow copy of the pool that tracks every accepted item.
    logic [SLOT_COUNT-1:0] shadow_map = '0;
    logic [CNT_W-1:0]      shadow_count = '0;
    logic [SLOT_W-1:0]     shadow_head = '0;

    t_pool_result pending_results[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           gaps_on = 1'b1;

    next_fit_bitmap_slot_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_free_slot    (i_free_slot),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_used_count   (o_used_count)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Works out the outcome of one item and advances the shadow pool.
    task automatic predict_pool_op(input logic cmd, input logic [7:0] slot);
        t_pool_result res;
        int           idx;
        bit           found;
        res.status = ST_OK;
        res.slot   = '0;
        found      = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (shadow_count < SLOT_COUNT) begin
                for (int n = 0; n < SLOT_COUNT && !found; n++) begin
                    idx = (int'(shadow_head) + n) % SLOT_COUNT;
                    if (!shadow_map[idx]) begin
                        found = 1'b1;
                        shadow_map[idx] = 1'b1;
                        shadow_count    = shadow_count + 1'b1;
                        shadow_head     = SLOT_W'((idx + 1) % SLOT_COUNT);
                        res.slot        = 8'(idx);
                    end
                end
            end
            if (!found) begin
                res.status = ST_FULL;
            end
        end else if (int'(slot) < SLOT_COUNT && shadow_map[slot]) begin
            shadow_map[slot] = 1'b0;
            if (shadow_count > 0) begin
                shadow_count = shadow_count - 1'b1;
            end
        end else begin
            res.status = ST_NOT_USED;
        end
        res.count = shadow_count;
        pending_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_pool_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d count=%0d", $time,
                         o_status, o_granted_slot, o_used_count);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, o_status);
                    error_count++;
                end
                if (o_granted_slot !== exp_res.slot) begin
                    $display("%0t: granted_slot expected %0d actual %0d", $time,
                             exp_res.slot, o_granted_slot);
                    error_count++;
                end
                if (o_used_count !== exp_res.count) begin
                    $display("%0t: used_count expected %0d actual %0d", $time,
                             exp_res.count, o_used_count);
                    error_count++;
                end
            end
        end
    end

    task automatic idle_burst(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Presents one item and returns at the edge that takes it, with start still high.
    task automatic send_item(input logic cmd, input logic [7:0] slot);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            idle_burst($urandom_range(1, 17));
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_command   <= cmd;
        i_free_slot <= slot;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_pool_op(cmd, slot);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_used_slot();
        int first;
        first = $urandom_range(0, SLOT_COUNT - 1);
        for (int n = 0; n < SLOT_COUNT; n++) begin
            if (shadow_map[(first + n) % SLOT_COUNT]) begin
                return 8'((first + n) % SLOT_COUNT);
            end
        end
        return 8'(first);
    endfunction

    task automatic test_empty_pool();
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_FREE, 8'd255);
        send_item(CMD_ALLOC, 8'd0);
        send_item(CMD_ALLOC, 8'd170);
        send_item(CMD_FREE, 8'd0);
        send_item(CMD_FREE, 8'd0);
        // Next fit: slot 0 is free again but the head has moved past it.
        send_item(CMD_ALLOC, 8'd85);
        send_item(CMD_FREE, 8'd1);
        send_item(CMD_FREE, 8'd2);
        send_item(CMD_FREE, 8'd2);
        send_item(CMD_ALLOC, 8'd0);
        wait_for_results();
    endtask

    task automatic test_full_and_wrap();
        while (shadow_count < SLOT_COUNT) begin
            send_item(CMD_ALLOC, 8'($urandom_range(0, 255)));
        end
        send_item(CMD_ALLOC, 8'd0);
        send_item(CMD_ALLOC, 8'd255);
        send_item(CMD_FREE, 8'd200);
        send_item(CMD_FREE, 8'd7);
        send_item(CMD_FREE, 8'd255);
        send_item(CMD_FREE, 8'd130);
        send_item(CMD_FREE, 8'd130);
        repeat (5) begin
            send_item(CMD_ALLOC, 8'd0);
        end
        wait_for_results();
    endtask

    // Frees mostly target live slots; the rest hit arbitrary, possibly free, slots.
    task automatic test_random_mix(input int items, input int alloc_pct);
        logic [7:0] slot;
        repeat (items) begin
            if ($urandom_range(1, 100) <= alloc_pct) begin
                send_item(CMD_ALLOC, 8'($urandom_range(0, 255)));
            end else begin
                slot = ($urandom_range(0, 9) < 8) ? pick_used_slot()
                                                  : 8'($urandom_range(0, 255));
                send_item(CMD_FREE, slot);
            end
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_mix(80, 75);
        test_random_mix(80, 25);
        wait_for_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pool();
        test_full_and_wrap();
        test_random_mix(160, 70);
        wait_for_results();
        test_random_mix(100, 30);
        test_random_mix(160, 50);
        wait_for_results();
        test_random_mix(40, 85);
        test_back_to_back();

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/nfba_pkg.sv
design/nfba_bitmap_ram.sv
design/next_fit_bitmap_slot_allocator.sv
bench/tb_next_fit_bitmap_slot_allocator.sv
